// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the flash record log writer RTL.
// Needs nothing else; files that check their own logic include it by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define FLRW_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("flrw assertion failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define FLRW_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("flrw assertion failed");

`endif

// ===== rtl/core/flrw_pkg.sv =====
// Package of the flash record log writer: sizes, codes, shared types and
// the slot geometry functions. Depends on nothing.
package flrw_pkg;

   // Flash geometry.
   localparam int PAGE_BYTES = 2048;
   localparam int PAGE_LOG2  = $clog2(PAGE_BYTES);
   localparam int PAGE_W     = PAGE_LOG2 + 1;
   localparam int ZONE_COUNT = 3;

   // Field and state widths.
   localparam int ADDR_W     = 32;
   localparam int DATA_W     = 16;
   localparam int ZONE_W     = 2;
   localparam int SHIFT_W    = 4;
   localparam int IDX_W      = 8;
   localparam int SLOTS_W    = IDX_W + 1;
   localparam int ACT_W      = $clog2(ZONE_COUNT + 1);
   localparam int CSUM_W     = 8;
   localparam int RB_W       = 12;
   localparam int CMP_W      = ((RB_W > PAGE_W) ? RB_W : PAGE_W) + 1;
   localparam int OFF_W      = 24;
   localparam int ZSEL_W     = (ZONE_COUNT > 1) ? $clog2(ZONE_COUNT) : 1;
   localparam int CSR_IDX_W  = 2;

   // Reset values of the configuration registers.
   localparam logic [ADDR_W-1:0] RESET_BASE = 32'h0801_7000;
   localparam logic [ZONE_COUNT-1:0][SHIFT_W-1:0] RESET_SHIFT = {4'd8, 4'd6, 4'd5};

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] REG_BASE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SHIFT0 = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SHIFT1 = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SHIFT2 = 2'd3;

   // Flash command codes.
   localparam logic [1:0] CMD_NONE    = 2'd0;
   localparam logic [1:0] CMD_ERASE   = 2'd1;
   localparam logic [1:0] CMD_PROGRAM = 2'd2;

   // Step status codes.
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_BAD_ZONE = 2'd1;
   localparam logic [1:0] ST_MISMATCH = 2'd2;
   localparam logic [1:0] ST_TOO_LONG = 2'd3;

   // Bit positions of the pending result kinds of one item.
   localparam int KIND_NONE  = 0;
   localparam int KIND_ERASE = 1;
   localparam int KIND_WORD  = 2;
   localparam int KIND_HLEN  = 3;
   localparam int KIND_HSUM  = 4;
   localparam int KIND_CNT   = 5;

   typedef struct packed {
      logic [ADDR_W-1:0]                     base_address;
      logic [ZONE_COUNT-1:0][SHIFT_W-1:0]    slot_shift;
   } flrw_cfg_type;

   typedef struct packed {
      logic [ZONE_W-1:0] zone;
      logic [DATA_W-1:0] word_data;
      logic              last_word;
   } flrw_item_type;

   // All results that one item causes, as a mask of kinds plus their fields.
   typedef struct packed {
      logic [KIND_CNT-1:0] kinds;
      logic [1:0]          status;
      logic [ADDR_W-1:0]   erase_addr;
      logic [ADDR_W-1:0]   word_addr;
      logic [DATA_W-1:0]   word_data;
      logic [ADDR_W-1:0]   hdr_address;
      logic [RB_W-1:0]     length;
      logic [CSUM_W-1:0]   csum;
   } flrw_list_type;

   // Slots in one page, clamped to 1..256.
   function automatic logic [SLOTS_W-1:0] slots_per_page(input logic [SHIFT_W-1:0] shift);
      logic [PAGE_W-1:0] n;
      n = PAGE_W'(PAGE_BYTES) >> shift;
      if (n == '0) begin
         n = PAGE_W'(1);
      end
      if (n > PAGE_W'(256)) begin
         n = PAGE_W'(256);
      end
      return SLOTS_W'(n);
   endfunction

   // Payload bytes a slot can hold: min(slot size, page size) minus the header.
   function automatic logic [PAGE_W-1:0] payload_limit(input logic [SHIFT_W-1:0] shift);
      logic [PAGE_W-1:0] sz;
      if (32'(shift) >= PAGE_LOG2) begin
         sz = PAGE_W'(PAGE_BYTES);
      end else begin
         sz = PAGE_W'(1) << shift;
      end
      return (sz < PAGE_W'(4)) ? '0 : sz - PAGE_W'(4);
   endfunction

   // Byte offset of a zone's page from the flash base.
   function automatic logic [OFF_W-1:0] page_offset(input logic [ZSEL_W-1:0] zone,
                                                    input logic              page);
      logic [OFF_W-1:0] pn;
      pn = (OFF_W'(zone) << 1) + OFF_W'(page);
      return OFF_W'(pn * OFF_W'(PAGE_BYTES));
   endfunction

endpackage

// ===== rtl/core/flrw_if.sv =====
// Valid/ready channel interfaces of the flash record log writer.
// Depends on flrw_pkg for field widths.
interface flrw_req_if;
   logic                         valid;
   logic                         ready;
   logic [flrw_pkg::ZONE_W-1:0]  zone;
   logic [flrw_pkg::DATA_W-1:0]  word_data;
   logic                         last_word;

   modport source (output valid, output zone, output word_data, output last_word,
                   input ready);
   modport sink   (input valid, input zone, input word_data, input last_word,
                   output ready);
endinterface

interface flrw_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [1:0]                   command;
   logic [flrw_pkg::ADDR_W-1:0]  flash_address;
   logic [flrw_pkg::DATA_W-1:0]  program_data;
   logic [1:0]                   status;
   logic                         last_result;

   modport source (output valid, output command, output flash_address,
                   output program_data, output status, output last_result,
                   input ready);
   modport sink   (input valid, input command, input flash_address,
                   input program_data, input status, input last_result,
                   output ready);
endinterface

// ===== rtl/core/flash_record_log_writer.sv =====
// Top level of the flash record log writer: configuration registers and the
// two stages. Uses flrw_pkg, flrw_if, flrw_record_ctrl and flrw_result_queue.
//
// The writer streams configuration records, one halfword per transfer on the
// req_ channel, into two-page zones of flash and turns each word into one to
// four results on the rsp_ channel: an erase when a zone's page is full, the
// program of the word itself, on the word marked last the length and checksum
// header writes, and an empty result with only a status when none of these
// apply. Every word is processed in the cycle it is accepted; its results are
// then held in a pending register, moved to the emitter's current register and
// sent one per transfer. The single result port therefore sets the rate: with
// an always-ready sink, a stream of plain words runs at one item per cycle.
// Because of the pending register the next word is accepted while the previous
// word's commands are still going out. There is no clearing pass after reset;
// the block is ready as soon as reset is released.
// Configuration registers are written through csr_write_enable, csr_index
// and csr_write_data and should be changed only while the block is idle.

module flash_record_log_writer (
   input  logic                              clock,
   input  logic                              reset,
   flrw_req_if.sink                          req_ch,
   flrw_rsp_if.source                        rsp_ch,
   input  logic                              csr_write_enable,
   input  logic [flrw_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [flrw_pkg::ADDR_W-1:0]       csr_write_data
);

   // Configuration registers: flash base address and the three slot shifts.
   flrw_pkg::flrw_cfg_type   cfg_ff, cfg_in;

   flrw_pkg::flrw_item_type  item;
   flrw_pkg::flrw_list_type  list;
   logic                     req_fire;
   logic                     in_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            flrw_pkg::REG_BASE: begin
               cfg_in.base_address = csr_write_data;
            end
            flrw_pkg::REG_SHIFT0: begin
               cfg_in.slot_shift[0] = csr_write_data[flrw_pkg::SHIFT_W-1:0];
            end
            flrw_pkg::REG_SHIFT1: begin
               cfg_in.slot_shift[1] = csr_write_data[flrw_pkg::SHIFT_W-1:0];
            end
            flrw_pkg::REG_SHIFT2: begin
               cfg_in.slot_shift[2] = csr_write_data[flrw_pkg::SHIFT_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.base_address <= flrw_pkg::RESET_BASE;
         cfg_ff.slot_shift   <= flrw_pkg::RESET_SHIFT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // A word transfer happens when the requester is valid and the pending
   // register is free or is handing its list to the emitter this cycle.
   assign req_ch.ready   = in_ready;
   assign req_fire       = req_ch.valid && in_ready;
   assign item.zone      = req_ch.zone;
   assign item.word_data = req_ch.word_data;
   assign item.last_word = req_ch.last_word;

   // Record state and command list for the accepted word.
   flrw_record_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg_ff),
      .fire  (req_fire),
      .item  (item),
      .list  (list)
   );

   // Pending list register and one-command-per-transfer emitter.
   flrw_result_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .load     (req_fire),
      .list_in  (list),
      .in_ready (in_ready),
      .rsp_ch   (rsp_ch)
   );

endmodule

// ===== rtl/core/flrw_record_ctrl.sv =====
// Record state of the log writer: per-zone slot index and page, the open
// record, and the list of flash commands for each accepted word. Uses flrw_pkg.
`include "assert_macros.svh"

module flrw_record_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  flrw_pkg::flrw_cfg_type  cfg,
   input  logic                    fire,
   input  flrw_pkg::flrw_item_type item,
   output flrw_pkg::flrw_list_type list
);

   logic [flrw_pkg::IDX_W-1:0]   slot_index_ff  [flrw_pkg::ZONE_COUNT];
   logic                         page_select_ff [flrw_pkg::ZONE_COUNT];
   logic [flrw_pkg::ACT_W-1:0]   active_zone_ff, active_zone_in;
   logic [flrw_pkg::ADDR_W-1:0]  head_address_ff, head_address_in;
   logic [flrw_pkg::ADDR_W-1:0]  write_address_ff, write_address_in;
   logic [flrw_pkg::CSUM_W-1:0]  checksum_ff, checksum_in;
   logic [flrw_pkg::RB_W-1:0]    record_bytes_ff, record_bytes_in;

   logic                         zone_ok;
   logic [flrw_pkg::ZSEL_W-1:0]  zsel;
   logic [flrw_pkg::ACT_W-1:0]   zone_tag;
   logic [flrw_pkg::SHIFT_W-1:0] shift;
   logic                         open_rec;
   logic                         mismatch;
   logic [flrw_pkg::SLOTS_W-1:0] next_slot;
   logic                         wrap;
   logic [flrw_pkg::IDX_W-1:0]   idx_new;
   logic                         page_new;
   logic [flrw_pkg::OFF_W-1:0]   slot_off;
   logic [flrw_pkg::ADDR_W-1:0]  new_head;
   logic [flrw_pkg::ADDR_W-1:0]  new_write;
   logic [flrw_pkg::ADDR_W-1:0]  cur_head;
   logic [flrw_pkg::ADDR_W-1:0]  cur_write;
   logic [flrw_pkg::RB_W-1:0]    cur_bytes;
   logic [flrw_pkg::CSUM_W-1:0]  cur_csum;
   logic                         too_long;
   logic                         do_word;
   logic                         do_head;
   logic                         commit;

   always_comb begin
      zone_ok  = 32'(item.zone) < flrw_pkg::ZONE_COUNT;
      zsel     = zone_ok ? flrw_pkg::ZSEL_W'(item.zone) : '0;
      zone_tag = flrw_pkg::ACT_W'(zsel) + flrw_pkg::ACT_W'(1);
      shift    = cfg.slot_shift[zsel];
      open_rec = (active_zone_ff == '0);
      mismatch = !open_rec && (active_zone_ff != zone_tag);

      // A new record takes the next slot; past the page end it erases and flips.
      next_slot = flrw_pkg::SLOTS_W'(slot_index_ff[zsel]) + flrw_pkg::SLOTS_W'(1);
      wrap      = open_rec && (next_slot >= flrw_pkg::slots_per_page(shift));
      idx_new   = wrap ? '0 : next_slot[flrw_pkg::IDX_W-1:0];
      page_new  = page_select_ff[zsel] ^ wrap;
      slot_off  = flrw_pkg::page_offset(zsel, page_new)
                  + (flrw_pkg::OFF_W'(idx_new) << shift);
      new_head  = cfg.base_address + flrw_pkg::ADDR_W'(slot_off);
      new_write = cfg.base_address + flrw_pkg::ADDR_W'(slot_off + flrw_pkg::OFF_W'(4));

      cur_head  = open_rec ? new_head : head_address_ff;
      cur_write = open_rec ? new_write : write_address_ff;
      cur_bytes = open_rec ? '0 : record_bytes_ff;
      cur_csum  = open_rec ? '0 : checksum_ff;

      too_long = (flrw_pkg::CMP_W'(cur_bytes) + flrw_pkg::CMP_W'(2))
                 > flrw_pkg::CMP_W'(flrw_pkg::payload_limit(shift));
      commit   = zone_ok && !mismatch;
      do_word  = commit && !too_long;
      do_head  = commit && item.last_word;

      record_bytes_in  = do_word ? cur_bytes + flrw_pkg::RB_W'(2) : cur_bytes;
      checksum_in      = do_word ? cur_csum ^ item.word_data[7:0] ^ item.word_data[15:8]
                                 : cur_csum;
      write_address_in = do_word ? cur_write + flrw_pkg::ADDR_W'(2) : cur_write;
      head_address_in  = cur_head;
      active_zone_in   = item.last_word ? '0 : zone_tag;

      list.kinds = '0;
      list.kinds[flrw_pkg::KIND_ERASE] = zone_ok && wrap;
      list.kinds[flrw_pkg::KIND_WORD]  = do_word;
      list.kinds[flrw_pkg::KIND_HLEN]  = do_head;
      list.kinds[flrw_pkg::KIND_HSUM]  = do_head;
      list.kinds[flrw_pkg::KIND_NONE]  = !((zone_ok && wrap) || do_word || do_head);

      if (!zone_ok) begin
         list.status = flrw_pkg::ST_BAD_ZONE;
      end else if (mismatch) begin
         list.status = flrw_pkg::ST_MISMATCH;
      end else if (too_long) begin
         list.status = flrw_pkg::ST_TOO_LONG;
      end else begin
         list.status = flrw_pkg::ST_OK;
      end

      list.erase_addr = cfg.base_address
                        + flrw_pkg::ADDR_W'(flrw_pkg::page_offset(zsel, page_select_ff[zsel]));
      list.word_addr   = cur_write;
      list.word_data   = item.word_data;
      list.hdr_address = cur_head;
      list.length      = record_bytes_in;
      list.csum        = checksum_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int z = 0; z < flrw_pkg::ZONE_COUNT; z++) begin
            slot_index_ff[z]  <= flrw_pkg::IDX_W'(
                                 flrw_pkg::slots_per_page(flrw_pkg::RESET_SHIFT[z])
                                 - flrw_pkg::SLOTS_W'(1));
            page_select_ff[z] <= 1'b1;
         end
         active_zone_ff   <= '0;
         head_address_ff  <= '0;
         write_address_ff <= '0;
         checksum_ff      <= '0;
         record_bytes_ff  <= '0;
      end else if (fire && commit) begin
         if (open_rec) begin
            slot_index_ff[zsel]  <= idx_new;
            page_select_ff[zsel] <= page_new;
         end
         active_zone_ff   <= active_zone_in;
         head_address_ff  <= head_address_in;
         write_address_ff <= write_address_in;
         checksum_ff      <= checksum_in;
         record_bytes_ff  <= record_bytes_in;
      end
   end

   // A rejected word leaves the open record untouched.
   `FLRW_ASSERT_NEXT(a_reject_zone, clock, reset, fire && !commit, $stable(active_zone_ff))
   `FLRW_ASSERT_NEXT(a_reject_bytes, clock, reset, fire && !commit, $stable(record_bytes_ff))
   // A last word on a valid zone that matches the open record always closes the record.
   `FLRW_ASSERT_NEXT(a_last_closes, clock, reset, fire && commit && item.last_word, active_zone_ff == '0)

endmodule

// ===== rtl/core/flrw_result_queue.sv =====
// Result side of the log writer: a pending list register that parts input
// from output, and an emitter that sends one flash command per transfer.
// Uses flrw_pkg and flrw_rsp_if.
`include "assert_macros.svh"

module flrw_result_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  flrw_pkg::flrw_list_type list_in,
   output logic                    in_ready,
   flrw_rsp_if.source              rsp_ch
);

   flrw_pkg::flrw_list_type         pend_ff, pend_in;
   logic                            pend_valid_ff, pend_valid_in;
   flrw_pkg::flrw_list_type         cur_ff, cur_in;
   logic [flrw_pkg::KIND_CNT-1:0]   cur_mask_ff, cur_mask_in;

   logic                            take;
   logic                            last_one;
   logic                            cur_free;

   always_comb begin
      take     = rsp_ch.valid && rsp_ch.ready;
      last_one = (cur_mask_ff != '0)
                 && ((cur_mask_ff & (cur_mask_ff - flrw_pkg::KIND_CNT'(1))) == '0);
      cur_free = (cur_mask_ff == '0) || (take && last_one);
      in_ready = !pend_valid_ff || cur_free;

      pend_valid_in = (pend_valid_ff && !cur_free) || load;
      pend_in       = load ? list_in : pend_ff;

      cur_in      = cur_ff;
      cur_mask_in = cur_mask_ff;
      if (cur_free) begin
         if (pend_valid_ff) begin
            cur_in      = pend_ff;
            cur_mask_in = pend_ff.kinds;
         end else begin
            cur_mask_in = '0;
         end
      end else if (take) begin
         // Drop the result just sent, the lowest pending kind.
         cur_mask_in = cur_mask_ff & (cur_mask_ff - flrw_pkg::KIND_CNT'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         cur_mask_ff   <= '0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         cur_mask_ff   <= cur_mask_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      cur_ff  <= cur_in;
   end

   always_comb begin
      rsp_ch.valid       = (cur_mask_ff != '0);
      rsp_ch.status      = cur_ff.status;
      rsp_ch.last_result = last_one;
      if (cur_mask_ff[flrw_pkg::KIND_ERASE]) begin
         rsp_ch.command       = flrw_pkg::CMD_ERASE;
         rsp_ch.flash_address = cur_ff.erase_addr;
         rsp_ch.program_data  = '0;
      end else if (cur_mask_ff[flrw_pkg::KIND_WORD]) begin
         rsp_ch.command       = flrw_pkg::CMD_PROGRAM;
         rsp_ch.flash_address = cur_ff.word_addr;
         rsp_ch.program_data  = cur_ff.word_data;
      end else if (cur_mask_ff[flrw_pkg::KIND_HLEN]) begin
         rsp_ch.command       = flrw_pkg::CMD_PROGRAM;
         rsp_ch.flash_address = cur_ff.hdr_address;
         rsp_ch.program_data  = flrw_pkg::DATA_W'(cur_ff.length);
      end else if (cur_mask_ff[flrw_pkg::KIND_HSUM]) begin
         rsp_ch.command       = flrw_pkg::CMD_PROGRAM;
         rsp_ch.flash_address = cur_ff.hdr_address + flrw_pkg::ADDR_W'(2);
         rsp_ch.program_data  = flrw_pkg::DATA_W'(cur_ff.csum);
      end else begin
         rsp_ch.command       = flrw_pkg::CMD_NONE;
         rsp_ch.flash_address = '0;
         rsp_ch.program_data  = '0;
      end
   end

   // A waiting list moves into an idle emitter without delay.
   `FLRW_ASSERT_NEXT(a_pend_moves, clock, reset, pend_valid_ff && cur_mask_ff == '0, cur_mask_ff != '0)
   // The empty result never travels with a real command.
   `FLRW_ASSERT_IMP(a_none_alone, clock, reset, cur_mask_ff[flrw_pkg::KIND_NONE], $onehot(cur_mask_ff))
   // Header length and checksum writes always come as a pair.
   `FLRW_ASSERT_IMP(a_head_pair, clock, reset, cur_mask_ff[flrw_pkg::KIND_HLEN], cur_mask_ff[flrw_pkg::KIND_HSUM])

endmodule
